FILE: hdl/mpsplit_pkg.sv
// Shared types and codes for the multipart boundary splitter.
package mpsplit_pkg;

  // Input function codes.
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_DATA = 2'd1;
  localparam logic [1:0] FUNC_END  = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FOUND = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Width of the boundary length write data.
  localparam int unsigned LEN_W = 7;

  // One input item.
  typedef struct packed {
    logic [1:0] func;
    logic [5:0] table_index;
    logic [7:0] byte_in;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_out;
  } out_item_t;

  // Per-cycle control broadcast to every cell of the window row.
  typedef struct packed {
    logic       data_en;
    logic       shift;
    logic       load_en;
    logic [5:0] load_idx;
    logic [7:0] byte_val;
  } cell_ctl_t;

endpackage

FILE: hdl/mpsplit_cell.sv
// One cell of the window row: a boundary byte, a held window byte and its compare.
module mpsplit_cell import mpsplit_pkg::*; #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned FILL_W = 6
) (
  input  logic              clk_i,
  input  cell_ctl_t         ctl_i,
  input  logic [FILL_W-1:0] fill_i,
  input  logic [7:0]        next_byte_i,
  output logic [7:0]        byte_o,
  output logic              match_o
);

  logic [7:0] tab_q;
  logic [7:0] win_q;
  logic [7:0] win_d;
  logic       is_tail;
  logic       in_use;

  // The incoming byte lands in the cell at the current fill position.
  assign is_tail = (fill_i == FILL_W'(IDX));
  assign in_use  = (FILL_W'(IDX) <= fill_i);
  assign byte_o  = is_tail ? ctl_i.byte_val : win_q;

  // Cells beyond the window never break the prefix test.
  assign match_o = !in_use || (byte_o == tab_q);

  // Shift toward the head on a mismatch, otherwise keep the candidate byte.
  always_comb begin
    win_d = win_q;
    if (ctl_i.data_en) begin
      win_d = ctl_i.shift ? next_byte_i : byte_o;
    end
  end

  // Boundary byte and window byte are payload only.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_en && (32'(ctl_i.load_idx) == IDX)) begin
      tab_q <= ctl_i.byte_val;
    end
    win_q <= win_d;
  end

endmodule

FILE: hdl/mpsplit_out_buf.sv
// Two-entry result buffer that decouples the input stall from the output stall.
module mpsplit_out_buf import mpsplit_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t push_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;
  logic      out_take;
  logic      out_free;

  assign out_take = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || out_take;

  // Refill from the skid entry first; new results go to whichever slot is open.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_free) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload slots.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/multipart_boundary_splitter.sv
// Top level of the multipart boundary splitter: control, cell row and result buffer.
//
// The splitter scans a byte stream for a boundary string loaded beforehand with load
// items (func 0), one byte per table position. For each data item (func 1) the byte is
// placed in a row of MAX_BOUNDARY cells, every cell compares its held byte with its
// boundary byte in parallel, and the AND of those compares decides whether the window
// grows, is reported as a found boundary, or releases its oldest byte as data while the
// row shifts by one cell. An end item (func 2) drops the held bytes and reports the end.
// One item is accepted every cycle while the result buffer has room; the rate is set by
// the parallel compare and reduction across the cell row. Results pass through a
// two-entry buffer, so in_stall_o rises only when both entries are occupied. Writing
// boundary_length (clamped to 1..MAX_BOUNDARY) also empties the window.
module multipart_boundary_splitter import mpsplit_pkg::*; #(
  parameter int unsigned MAX_BOUNDARY = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_data_i
);

  localparam int unsigned FILL_W = $clog2(MAX_BOUNDARY);

  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [FILL_W-1:0]   len_m1_q, len_m1_d;
  logic                accept;
  logic                buf_full;
  logic                is_data;
  logic                prefix;
  logic                found;
  logic                push;
  out_item_t           push_data;
  cell_ctl_t           ctl;
  logic [MAX_BOUNDARY-1:0] match;
  logic [7:0]          cell_byte [MAX_BOUNDARY+1];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign accept      = in_valid_i && !buf_full;
  assign is_data     = accept && (in_data_i.func == FUNC_DATA);

  // Window matches the boundary prefix when every cell in use agrees.
  assign prefix = &match;
  assign found  = prefix && (fill_q == len_m1_q);

  // Control broadcast to the cell row.
  always_comb begin
    ctl.data_en  = is_data;
    ctl.shift    = !prefix;
    ctl.load_en  = accept && (in_data_i.func == FUNC_LOAD);
    ctl.load_idx = in_data_i.table_index;
    ctl.byte_val = in_data_i.byte_in;
  end

  // Cell row; each cell hands its byte to the cell in front of it on a shift.
  assign cell_byte[MAX_BOUNDARY] = 8'h00;
  for (genvar i = 0; i < MAX_BOUNDARY; i++) begin : g_cell
    mpsplit_cell #(
      .IDX    (i),
      .FILL_W (FILL_W)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .fill_i      (fill_q),
      .next_byte_i (cell_byte[i+1]),
      .byte_o      (cell_byte[i]),
      .match_o     (match[i])
    );
  end

  // Result selection and window fill update.
  always_comb begin
    push               = 1'b0;
    push_data.kind     = KIND_DATA;
    push_data.byte_out = 8'h00;
    fill_d             = fill_q;
    if (accept) begin
      case (in_data_i.func)
        FUNC_DATA: begin
          if (found) begin
            push           = 1'b1;
            push_data.kind = KIND_FOUND;
            fill_d         = '0;
          end else if (prefix) begin
            fill_d = fill_q + FILL_W'(1);
          end else begin
            push               = 1'b1;
            push_data.byte_out = cell_byte[0];
          end
        end
        FUNC_END: begin
          push           = 1'b1;
          push_data.kind = KIND_END;
          fill_d         = '0;
        end
        default: begin
        end
      endcase
    end
    if (cfg_valid_i) begin
      fill_d = '0;
    end
  end

  // Clamp the written length to 1..MAX_BOUNDARY and keep it minus one.
  always_comb begin
    len_m1_d = len_m1_q;
    if (cfg_valid_i) begin
      if (cfg_data_i == '0) begin
        len_m1_d = '0;
      end else if (32'(cfg_data_i) > MAX_BOUNDARY) begin
        len_m1_d = FILL_W'(MAX_BOUNDARY - 1);
      end else begin
        len_m1_d = FILL_W'(cfg_data_i - LEN_W'(1));
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      len_m1_q <= FILL_W'(3);
    end else begin
      fill_q   <= fill_d;
      len_m1_q <= len_m1_d;
    end
  end

  // Result buffer.
  mpsplit_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
